// ----- src/gsq_pkg.sv -----
// Shared types, constants and register codes of the satellite qualifier.
`timescale 1ns / 1ps

package gsq_pkg;

  // Default number of map slots and width of the map epoch tag.
  localparam int SAT_SLOTS_DEF = 256;
  localparam int EPOCH_W       = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEV_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CN0_THR   = 1'b1;

  // Register reset values.
  localparam logic signed [14:0] ELEV_MASK_RST = 15'sd1000;
  localparam logic [7:0]         CN0_THR_RST   = 8'd120;

  // Magnitudes at or below these mark a measurement as absent.
  localparam logic signed [43:0] PR_LIMIT = 44'sd16;
  localparam logic signed [47:0] CP_LIMIT = 48'sd256;

  // Satellite number ranges of the four systems.
  localparam logic [7:0] GPS_MIN = 8'd1;
  localparam logic [7:0] GPS_MAX = 8'd39;
  localparam logic [7:0] GAL_MIN = 8'd41;
  localparam logic [7:0] GAL_MAX = 8'd70;
  localparam logic [7:0] BDS_MIN = 8'd71;
  localparam logic [7:0] BDS_MAX = 8'd100;
  localparam logic [7:0] GLO_MIN = 8'd101;
  localparam logic [7:0] GLO_MAX = 8'd130;

  // Counter and flag slots of the systems.
  localparam int SYS_GPS = 0;
  localparam int SYS_GAL = 1;
  localparam int SYS_BDS = 2;
  localparam int SYS_GLO = 3;

  localparam logic [7:0] COUNT_MAX   = 8'hFF;
  localparam logic [2:0] MIN_SV_BASE = 3'd3;

  // One observation request.
  typedef struct packed {
    logic                receiver;
    logic [7:0]          prn;
    logic signed [14:0]  elevation;
    logic [7:0]          cn0;
    logic signed [43:0]  pseudorange;
    logic signed [47:0]  carrier_phase;
    logic [2:0]          lli;
    logic                has_ephemeris;
    logic [5:0]          health_code;
    logic                last;
  } obs_t;

  typedef logic [3:0][7:0] counts_t;

  // Commands from the pipeline to the base map.
  typedef struct packed {
    logic start_sweep;
    logic new_list;
    logic write;
  } map_cmd_t;

  // Status of the base map.
  typedef struct packed {
    logic busy;
    logic full;
    logic marked;
  } map_sts_t;

  // Judgment of one observation.
  typedef struct packed {
    logic       ok;
    counts_t    counts;
    logic [3:0] present;
  } verdict_t;

endpackage

// ----- src/gsq_ram.sv -----
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps

module gsq_ram #(
  parameter int WIDTH = gsq_pkg::EPOCH_W,
  parameter int DEPTH = gsq_pkg::SAT_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write first in program order; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/gsq_map.sv -----
// Base satellite map: epoch-tagged RAM, clearing sweep and write forwarding.
`timescale 1ns / 1ps

module gsq_map #(
  parameter int SAT_SLOTS = gsq_pkg::SAT_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gsq_pkg::map_cmd_t            cmd_i,
  input  logic [$clog2(SAT_SLOTS)-1:0] wr_addr_i,
  input  logic [$clog2(SAT_SLOTS)-1:0] rd_addr_i,
  output gsq_pkg::map_sts_t            sts_o
);

  import gsq_pkg::*;

  localparam int ADDR_W = $clog2(SAT_SLOTS);

  logic [EPOCH_W-1:0] epoch_q;
  logic [EPOCH_W-1:0] epoch_d;
  logic               sweep_q;
  logic [ADDR_W-1:0]  sweep_cnt_q;
  logic               fwd_q;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata;
  logic [EPOCH_W-1:0] rd_tag;

  // A new base list moves to a fresh epoch, which clears the map at once.
  assign epoch_d = cmd_i.new_list ? epoch_q + EPOCH_W'(1) : epoch_q;

  // The sweep owns the write port; otherwise a kept base satellite is tagged.
  assign ram_we    = sweep_q | cmd_i.write;
  assign ram_waddr = sweep_q ? sweep_cnt_q : wr_addr_i;
  assign ram_wdata = sweep_q ? '0 : epoch_d;

  gsq_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (SAT_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_tag)
  );

  // Epoch, clearing sweep and forwarding of a write to the same slot.
  // Reset starts in epoch one, so base satellites kept before the first base list
  // are tagged with a value that the swept RAM does not hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= EPOCH_W'(1);
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      fwd_q       <= 1'b0;
    end else begin
      if (sweep_q) begin
        if (sweep_cnt_q == ADDR_W'(SAT_SLOTS - 1)) begin
          sweep_q     <= 1'b0;
          sweep_cnt_q <= '0;
        end else begin
          sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
        end
      end else if (cmd_i.start_sweep) begin
        sweep_q <= 1'b1;
        epoch_q <= '0;
      end else begin
        epoch_q <= epoch_d;
      end
      fwd_q <= cmd_i.write && (wr_addr_i == rd_addr_i);
    end
  end

  // Epoch zero only lasts from a sweep request to the base list behind it and marks nothing.
  assign sts_o.marked = fwd_q || ((rd_tag == epoch_q) && (epoch_q != '0));
  assign sts_o.busy   = sweep_q;
  assign sts_o.full   = (epoch_q == '1);

endmodule

// ----- src/gsq_judge.sv -----
// Observation checks and per-system counter update for one request.
`timescale 1ns / 1ps

module gsq_judge (
  input  gsq_pkg::obs_t           obs_i,
  input  logic signed [14:0]      elev_mask_i,
  input  logic [7:0]              cn0_thr_i,
  input  logic                    marked_i,
  input  logic                    in_map_i,
  input  logic                    list_start_i,
  input  gsq_pkg::counts_t        counts_i,
  input  logic [3:0]              present_i,
  output gsq_pkg::verdict_t       verdict_o
);

  import gsq_pkg::*;

  logic common_ok;
  logic ok;

  // Checks shared by both lists.
  assign common_ok = (obs_i.elevation > elev_mask_i) &&
                     (obs_i.cn0 > cn0_thr_i) &&
                     ((obs_i.pseudorange > PR_LIMIT) || (obs_i.pseudorange < -PR_LIMIT)) &&
                     ((obs_i.carrier_phase > CP_LIMIT) ||
                      (obs_i.carrier_phase < -CP_LIMIT)) &&
                     (obs_i.lli == 3'd0);

  // Base items need ephemeris and good health; rover items need a base match.
  assign ok = obs_i.receiver ?
              (common_ok && obs_i.has_ephemeris && (obs_i.health_code == 6'd0)) :
              (common_ok && in_map_i && marked_i);

  // Counters restart with the list, then the kept satellite's system is bumped.
  always_comb begin
    counts_t    cnt;
    logic [3:0] pres;
    cnt  = list_start_i ? '0 : counts_i;
    pres = list_start_i ? 4'd0 : present_i;
    if (ok) begin
      if (obs_i.prn <= GPS_MAX) begin
        pres[SYS_GPS] = 1'b1;
        if (obs_i.prn >= GPS_MIN && cnt[SYS_GPS] != COUNT_MAX) begin
          cnt[SYS_GPS] = cnt[SYS_GPS] + 8'd1;
        end
      end else if (obs_i.prn inside {[GAL_MIN:GAL_MAX]}) begin
        pres[SYS_GAL] = 1'b1;
        if (cnt[SYS_GAL] != COUNT_MAX) begin
          cnt[SYS_GAL] = cnt[SYS_GAL] + 8'd1;
        end
      end else if (obs_i.prn inside {[BDS_MIN:BDS_MAX]}) begin
        pres[SYS_BDS] = 1'b1;
        if (cnt[SYS_BDS] != COUNT_MAX) begin
          cnt[SYS_BDS] = cnt[SYS_BDS] + 8'd1;
        end
      end else if (obs_i.prn inside {[GLO_MIN:GLO_MAX]}) begin
        pres[SYS_GLO] = 1'b1;
        if (cnt[SYS_GLO] != COUNT_MAX) begin
          cnt[SYS_GLO] = cnt[SYS_GLO] + 8'd1;
        end
      end
    end
    verdict_o.ok      = ok;
    verdict_o.counts  = cnt;
    verdict_o.present = pres;
  end

endmodule

// ----- src/gnss_satellite_qualifier.sv -----
// Top level of the GNSS satellite qualifier: input stage, judgment and result register.
`timescale 1ns / 1ps

// Usage:
// Observations enter on the in channel (in_valid_i / in_stall_o), one per request,
// base list first, each list closed by last_i. Every observation yields one result on
// the out channel (out_valid_o / out_stall_i) with the keep decision, the running
// per-system counts of the current list and the minimum satellite number.
// An accepted request is held in the input register, judged, and its result is
// loaded into the result register. One request is taken per cycle while in_stall_o
// is low; the judgment between the two registers is combinational, and the base map
// RAM is read when a request is accepted. After reset, and again each time the 8-bit
// map epoch tag runs out (254 base lists after reset, every 255 after that), all
// SAT_SLOTS slots of the map RAM are swept, during which in_stall_o is high
// (configuration writes still land). Reset sets elevation mask 1000 and C/N0
// threshold 120. When the receiver stalls, the result holds, the next request
// waits in the input register, and in_stall_o rises once both are full.
// Configuration writes are taken whenever cfg_we_i is high.

module gnss_satellite_qualifier #(
  parameter int SAT_SLOTS = gsq_pkg::SAT_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port
  input  logic                            cfg_we_i,
  input  logic [gsq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gsq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Observation channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            receiver_i,
  input  logic [7:0]                      prn_i,
  input  logic signed [14:0]              elevation_i,
  input  logic [7:0]                      cn0_i,
  input  logic signed [43:0]              pseudorange_i,
  input  logic signed [47:0]              carrier_phase_i,
  input  logic [2:0]                      lli_i,
  input  logic                            has_ephemeris_i,
  input  logic [5:0]                      health_code_i,
  input  logic                            last_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      sat_id_o,
  output logic                            accepted_o,
  output logic [7:0]                      gps_count_o,
  output logic [7:0]                      galileo_count_o,
  output logic [7:0]                      beidou_count_o,
  output logic [7:0]                      glonass_count_o,
  output logic [2:0]                      min_sv_num_o,
  output logic                            list_end_o
);

  import gsq_pkg::*;

  localparam int ADDR_W = $clog2(SAT_SLOTS);

  logic signed [14:0] elev_mask_q;
  logic [7:0]         cn0_thr_q;

  logic               s1_valid_q;
  obs_t               s1_q;
  logic               s1_go;
  logic               in_acc;
  logic               need_new;

  logic               list_starting_q;
  counts_t            counts_q;
  logic [3:0]         present_q;

  logic               out_valid_q;
  logic [7:0]         sat_id_q;
  logic               accepted_q;
  counts_t            out_counts_q;
  logic [2:0]         min_sv_q;
  logic               list_end_q;

  map_cmd_t           map_cmd;
  map_sts_t           map_sts;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  s1_addr;
  logic               in_map;
  verdict_t           verdict;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elev_mask_q <= ELEV_MASK_RST;
      cn0_thr_q   <= CN0_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ELEV_MASK: elev_mask_q <= cfg_data_i;
        CFG_CN0_THR:   cn0_thr_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: the held request moves on when the map is ready and the result slot frees.
  assign need_new   = s1_q.receiver && list_starting_q;
  assign s1_go      = s1_valid_q && !map_sts.busy && !(need_new && map_sts.full) &&
                      (!out_valid_q || !out_stall_i);
  assign in_stall_o = map_sts.busy || (s1_valid_q && !s1_go);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc || (s1_valid_q && !s1_go);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.receiver      <= receiver_i;
      s1_q.prn           <= prn_i;
      s1_q.elevation     <= elevation_i;
      s1_q.cn0           <= cn0_i;
      s1_q.pseudorange   <= pseudorange_i;
      s1_q.carrier_phase <= carrier_phase_i;
      s1_q.lli           <= lli_i;
      s1_q.has_ephemeris <= has_ephemeris_i;
      s1_q.health_code   <= health_code_i;
      s1_q.last          <= last_i;
    end
  end

  // Map lookup: a held request rereads its own slot, otherwise the incoming one is read.
  assign s1_addr = ADDR_W'(s1_q.prn);
  assign rd_addr = (s1_valid_q && !s1_go) ? s1_addr : ADDR_W'(prn_i);
  assign in_map  = (ADDR_W + 1)'(s1_q.prn) < (ADDR_W + 1)'(SAT_SLOTS);

  assign map_cmd.start_sweep = s1_valid_q && need_new && map_sts.full && !map_sts.busy;
  assign map_cmd.new_list    = s1_go && need_new;
  assign map_cmd.write       = s1_go && s1_q.receiver && verdict.ok && in_map;

  gsq_map #(
    .SAT_SLOTS (SAT_SLOTS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (map_cmd),
    .wr_addr_i (s1_addr),
    .rd_addr_i (rd_addr),
    .sts_o     (map_sts)
  );

  gsq_judge u_judge (
    .obs_i        (s1_q),
    .elev_mask_i  (elev_mask_q),
    .cn0_thr_i    (cn0_thr_q),
    .marked_i     (map_sts.marked),
    .in_map_i     (in_map),
    .list_start_i (list_starting_q),
    .counts_i     (counts_q),
    .present_i    (present_q),
    .verdict_o    (verdict)
  );

  // List state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_starting_q <= 1'b1;
      counts_q        <= '0;
      present_q       <= 4'd0;
    end else if (s1_go) begin
      list_starting_q <= s1_q.last;
      counts_q        <= verdict.counts;
      present_q       <= verdict.present;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_go || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      sat_id_q     <= s1_q.prn;
      accepted_q   <= verdict.ok;
      out_counts_q <= verdict.counts;
      min_sv_q     <= MIN_SV_BASE + 3'($countones(verdict.present));
      list_end_q   <= s1_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sat_id_o        = sat_id_q;
  assign accepted_o      = accepted_q;
  assign gps_count_o     = out_counts_q[SYS_GPS];
  assign galileo_count_o = out_counts_q[SYS_GAL];
  assign beidou_count_o  = out_counts_q[SYS_BDS];
  assign glonass_count_o = out_counts_q[SYS_GLO];
  assign min_sv_num_o    = min_sv_q;
  assign list_end_o      = list_end_q;

endmodule
